// ----- hdl/qrs_energy_filter_chain_assert.svh -----
// assertion macros shared by the qrs energy filter chain
`ifndef QRS_ENERGY_FILTER_CHAIN_ASSERT_SVH
`define QRS_ENERGY_FILTER_CHAIN_ASSERT_SVH

`ifndef ASSERT_OFF
`define QEF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("qef assertion failed");
`define QEF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("qef assertion failed");
`else
`define QEF_ASSERT(lbl, prop)
`define QEF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hdl/qef_pkg.sv -----
// shared types and constants for the qrs energy filter chain
`default_nettype none

package qef_pkg;

  localparam int SAMPLE_W = 16;

  localparam int LP_TAPS = 12;
  localparam int LP_MID = LP_TAPS / 2 - 1;

  localparam int HP_TAPS = 32;
  localparam int HP_MID = HP_TAPS / 2 - 1;
  localparam int HP_SHIFT = 5;

  localparam int SL_TAPS = 4;
  localparam int SL_SHIFT = 3;
  localparam int SLOPE_SUM_W = SAMPLE_W + SL_SHIFT;

  localparam int BLANK_SAMPLES = 50;
  localparam int BLANK_CNT_W = $clog2(BLANK_SAMPLES + 1);

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

// ----- hdl/qef_lowpass.sv -----
// low-pass stage: y = 2y1 - y2 + x - 2x6 + x12, registered result
`default_nettype none

module qef_lowpass (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire qef_pkg::sample_t up_data,
  output logic                  valid,
  input  wire logic             down_ready,
  output qef_pkg::sample_t      data
);
  import qef_pkg::*;

  sample_t x_dly [LP_TAPS];
  sample_t y_dly [2];
  sample_t data_next;
  logic    load;

  assign up_ready = !valid || down_ready;
  assign load = up_valid && up_ready;

  always_comb begin
    data_next = {y_dly[0][SAMPLE_W-2:0], 1'b0} - y_dly[1] + up_data
              - {x_dly[LP_MID][SAMPLE_W-2:0], 1'b0} + x_dly[LP_TAPS-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      for (int i = 0; i < LP_TAPS; i++) x_dly[i] <= '0;
      y_dly[0] <= '0;
      y_dly[1] <= '0;
    end else begin
      if (up_ready) valid <= up_valid;
      if (load) begin
        x_dly[0] <= up_data;
        for (int i = 1; i < LP_TAPS; i++) x_dly[i] <= x_dly[i-1];
        y_dly[0] <= data_next;
        y_dly[1] <= y_dly[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= data_next;
  end

endmodule

`default_nettype wire

// ----- hdl/qef_highpass.sv -----
// high-pass stage: y = y1 - (x>>5) + x16 - x17 + (x32>>5), registered result
`default_nettype none

module qef_highpass (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire qef_pkg::sample_t up_data,
  output logic                  valid,
  input  wire logic             down_ready,
  output qef_pkg::sample_t      data
);
  import qef_pkg::*;

  sample_t x_dly [HP_TAPS];
  sample_t y_last;
  sample_t data_next;
  logic    load;

  assign up_ready = !valid || down_ready;
  assign load = up_valid && up_ready;

  always_comb begin
    data_next = y_last - (up_data >> HP_SHIFT) + x_dly[HP_MID] - x_dly[HP_MID+1]
              + (x_dly[HP_TAPS-1] >> HP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      y_last <= '0;
      for (int i = 0; i < HP_TAPS; i++) x_dly[i] <= '0;
    end else begin
      if (up_ready) valid <= up_valid;
      if (load) begin
        x_dly[0] <= up_data;
        for (int i = 1; i < HP_TAPS; i++) x_dly[i] <= x_dly[i-1];
        y_last <= data_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= data_next;
  end

endmodule

`default_nettype wire

// ----- hdl/qef_slope.sv -----
// slope stage: (2x + x1 - x3 - 2x4) >> 3 with start-up blank flag
`default_nettype none
`include "qrs_energy_filter_chain_assert.svh"

module qef_slope (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             blank_enable,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire qef_pkg::sample_t up_data,
  output logic                  valid,
  input  wire logic             down_ready,
  output qef_pkg::sample_t      data,
  output logic                  blank
);
  import qef_pkg::*;

  sample_t                  x_dly [SL_TAPS];
  logic [SLOPE_SUM_W-1:0]   sum;
  logic [BLANK_CNT_W-1:0]   blank_cnt;
  logic                     in_window;
  logic                     load;

  assign up_ready = !valid || down_ready;
  assign load = up_valid && up_ready;
  assign in_window = blank_cnt < BLANK_CNT_W'(BLANK_SAMPLES);

  // modular sum is exact here, so the top bits carry the sign
  always_comb begin
    sum = (SLOPE_SUM_W'(up_data) << 1) + SLOPE_SUM_W'(x_dly[0])
        - SLOPE_SUM_W'(x_dly[2]) - (SLOPE_SUM_W'(x_dly[SL_TAPS-1]) << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      blank_cnt <= '0;
      for (int i = 0; i < SL_TAPS; i++) x_dly[i] <= '0;
    end else begin
      if (up_ready) valid <= up_valid;
      if (load) begin
        x_dly[0] <= up_data;
        for (int i = 1; i < SL_TAPS; i++) x_dly[i] <= x_dly[i-1];
        if (in_window) blank_cnt <= blank_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data  <= sum[SL_SHIFT +: SAMPLE_W];
      blank <= blank_enable && in_window;
    end
  end

  `QEF_ASSERT(a_blank_cnt_bound, blank_cnt <= BLANK_CNT_W'(BLANK_SAMPLES))

endmodule

`default_nettype wire

// ----- hdl/qef_square.sv -----
// energy stage: low 16 bits of slope squared, result register
`default_nettype none

module qef_square (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire qef_pkg::sample_t up_data,
  input  wire logic             up_blank,
  output logic                  valid,
  input  wire logic             down_ready,
  output qef_pkg::sample_t      energy,
  output qef_pkg::sample_t      slope
);
  import qef_pkg::*;

  sample_t prod;
  logic    load;

  assign up_ready = !valid || down_ready;
  assign load = up_valid && up_ready;
  assign prod = up_data * up_data;

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (up_ready) valid <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      energy <= up_blank ? '0 : prod;
      slope  <= up_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/qrs_energy_filter_chain.sv -----
// top level of the qrs energy filter chain
`default_nettype none
`include "qrs_energy_filter_chain_assert.svh"

// Integer QRS energy filter: each ECG sample item runs through low-pass,
// high-pass, slope and squaring stages and gives one result item with the
// slope and its squared energy. An input register and four stage registers
// form a five-deep pipeline; low-pass, high-pass and slope keep delay lines,
// and every stage takes a new item each cycle unless the output stalls, so
// the chain then sustains one item per clock. An accepted item passes the
// input register and the low-pass, high-pass, slope and square registers
// before out_valid rises. Each stage has its own ready, so bubbles close up
// while a result waits at the output. With blank_enable set (its reset
// value) energy_out is zero for the first 50 items after reset; slope_out
// is never blanked. Write blank_enable only while the chain is empty.
module qrs_energy_filter_chain (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire qef_pkg::sample_t sample_in,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output qef_pkg::sample_t      energy_out,
  output qef_pkg::sample_t      slope_out
);
  import qef_pkg::*;

  logic    blank_enable;
  logic    in_reg_valid;
  sample_t in_reg;
  logic    lp_ready, lp_valid;
  sample_t lp_data;
  logic    hp_ready, hp_valid;
  sample_t hp_data;
  logic    sl_ready, sl_valid, sl_blank;
  sample_t sl_data;
  logic    sq_ready;

  always_ff @(posedge clk) begin
    if (rst) blank_enable <= 1'b1;
    else if (cfg_we) blank_enable <= cfg_wdata;
  end

  assign in_ready = !in_reg_valid || lp_ready;

  always_ff @(posedge clk) begin
    if (rst) in_reg_valid <= 1'b0;
    else if (in_ready) in_reg_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_reg <= sample_in;
  end

  qef_lowpass u_lowpass (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_reg_valid),
    .up_ready   (lp_ready),
    .up_data    (in_reg),
    .valid      (lp_valid),
    .down_ready (hp_ready),
    .data       (lp_data)
  );

  qef_highpass u_highpass (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (lp_valid),
    .up_ready   (hp_ready),
    .up_data    (lp_data),
    .valid      (hp_valid),
    .down_ready (sl_ready),
    .data       (hp_data)
  );

  qef_slope u_slope (
    .clk          (clk),
    .rst          (rst),
    .blank_enable (blank_enable),
    .up_valid     (hp_valid),
    .up_ready     (sl_ready),
    .up_data      (hp_data),
    .valid        (sl_valid),
    .down_ready   (sq_ready),
    .data         (sl_data),
    .blank        (sl_blank)
  );

  qef_square u_square (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (sl_valid),
    .up_ready   (sq_ready),
    .up_data    (sl_data),
    .up_blank   (sl_blank),
    .valid      (out_valid),
    .down_ready (out_ready),
    .energy     (energy_out),
    .slope      (slope_out)
  );

  // input only backs up when every stage is full and the output is stalled
  `QEF_ASSERT(a_stall_only_when_full,
    !in_ready |-> (out_valid && !out_ready && sl_valid && hp_valid && lp_valid))
  `QEF_ASSERT_ALWAYS(a_empty_after_reset, $past(rst) |-> !out_valid && !in_reg_valid)

endmodule

`default_nettype wire

// ----- tb/sv/tb_qrs_energy_filter_chain.sv -----
// self-checking testbench for the qrs energy filter chain with a built-in sample predictor
`timescale 1ns / 100ps

module tb_qrs_energy_filter_chain;

  import qef_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RELEASE_CYCLES = 120;
  localparam int PIPE_DEPTH = 5;
  localparam int NUM_DIRECTED = 20;

  typedef struct packed {
    sample_t sample;
    logic    typed;
    sample_t energy;
    sample_t slope;
  } row_t;

  typedef struct {
    sample_t energy;
    sample_t slope;
  } result_t;

  typedef struct {
    bit      typed;
    sample_t energy;
    sample_t slope;
  } tag_t;

  // typed rows: a zero item after reset, then full scale into empty delay lines
  localparam row_t DIRECTED [0:NUM_DIRECTED-1] = '{
    '{16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{16'hFFFF, 1'b1, 16'h0000, 16'h3E00},
    '{16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h0001, 1'b0, 16'h0000, 16'h0000},
    '{16'hFFFE, 1'b0, 16'h0000, 16'h0000},
    '{16'hAAAA, 1'b0, 16'h0000, 16'h0000},
    '{16'h5555, 1'b0, 16'h0000, 16'h0000},
    '{16'h00FF, 1'b0, 16'h0000, 16'h0000},
    '{16'hFF00, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'h1234, 1'b0, 16'h0000, 16'h0000}
  };

  logic    clk;
  logic    rst;
  logic    cfg_we;
  logic    cfg_wdata;
  logic    in_valid;
  logic    in_ready;
  sample_t sample_in;
  logic    out_valid;
  logic    out_ready;
  sample_t energy_out;
  sample_t slope_out;

  qrs_energy_filter_chain uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .energy_out (energy_out),
    .slope_out  (slope_out)
  );

  // predictor state
  sample_t     lp_in_line [LP_TAPS];
  sample_t     lp_out_line [2];
  sample_t     hp_in_line [HP_TAPS];
  sample_t     hp_out_last;
  sample_t     slope_line [SL_TAPS];
  int unsigned blank_count;
  bit          blank_en;

  result_t energy_due [$];
  tag_t    offer_tags [$];

  int      tx_idle_pct;
  int      rx_stall_pct;
  bit      pressure_on;
  int      hold_left;
  int      release_left;
  int      holds_done;
  int      stall_cycles;
  int      items_in;
  int      results_out;
  int      mismatches;
  int      strays;
  int      cfg_writes;
  sample_t wave_level;
  result_t got;
  result_t want;
  tag_t    tag;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic predict_energy(input sample_t x, output sample_t e, output sample_t d);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sum;
    logic [31:0] q;
    logic [31:0] sq;
    bit          blanked;
    a = (32'd2 * lp_out_line[0] - lp_out_line[1] + x - 32'd2 * lp_in_line[5]
         + lp_in_line[11]) & 32'hFFFF;
    for (int i = LP_TAPS - 1; i > 0; i--) lp_in_line[i] = lp_in_line[i-1];
    lp_in_line[0] = x;
    lp_out_line[1] = lp_out_line[0];
    lp_out_line[0] = a[15:0];
    b = (32'(hp_out_last) - (a >> HP_SHIFT) + hp_in_line[15] - hp_in_line[16]
         + (32'(hp_in_line[31]) >> HP_SHIFT)) & 32'hFFFF;
    for (int i = HP_TAPS - 1; i > 0; i--) hp_in_line[i] = hp_in_line[i-1];
    hp_in_line[0] = a[15:0];
    hp_out_last = b[15:0];
    sum = 32'd2 * b + slope_line[0] - slope_line[2] - 32'd2 * slope_line[3];
    q = sum[31] ? ((sum >> SL_SHIFT) | 32'hE000_0000) : (sum >> SL_SHIFT);
    for (int i = SL_TAPS - 1; i > 0; i--) slope_line[i] = slope_line[i-1];
    slope_line[0] = b[15:0];
    sq = {16'd0, q[15:0]} * {16'd0, q[15:0]};
    blanked = blank_en && (blank_count < BLANK_SAMPLES);
    if (blank_count < BLANK_SAMPLES) blank_count++;
    d = q[15:0];
    e = blanked ? 16'h0000 : sq[15:0];
  endtask

  // accepted items feed the predictor, accepted results are checked
  always @(posedge clk) begin
    if (!rst) begin
      stall_cycles++;
      if (out_valid && out_ready) begin
        stall_cycles = 0;
        results_out++;
        got.energy = energy_out;
        got.slope = slope_out;
        if (energy_due.size() == 0) begin
          strays++;
          if (mismatches + strays <= 10)
            $display("unexpected result: energy %h slope %h", got.energy, got.slope);
        end else begin
          want = energy_due.pop_front();
          if (got.energy !== want.energy || got.slope !== want.slope) begin
            mismatches++;
            if (mismatches + strays <= 10)
              $display("result %0d: expected energy %h slope %h, got energy %h slope %h",
                       results_out, want.energy, want.slope, got.energy, got.slope);
          end
        end
      end
      if (in_valid && in_ready) begin
        stall_cycles = 0;
        items_in++;
        predict_energy(sample_in, want.energy, want.slope);
        tag = offer_tags.pop_front();
        if (tag.typed) begin
          want.energy = tag.energy;
          want.slope = tag.slope;
        end
        energy_due.push_back(want);
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("[qrs_energy_filter_chain] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls plus long hold-offs under pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_on && hold_left == 0 && release_left == 0) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
        if (hold_left == 0) release_left = RELEASE_CYCLES;
      end else begin
        if (release_left > 0) release_left--;
        out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  function automatic sample_t next_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      wave_level = sample_t'($urandom);
    end else if (pick < 8) begin
      wave_level = wave_level + sample_t'($urandom_range(0, 512)) - 16'd256;
    end else if (pick == 8) begin
      wave_level = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    return wave_level;
  endfunction

  task automatic offer_sample(input sample_t s, input tag_t t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    offer_tags.push_back(t);
    in_valid = 1'b1;
    sample_in = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_blanking(input bit en);
    while (energy_due.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = en;
    @(negedge clk);
    cfg_we = 1'b0;
    blank_en = en;
    cfg_writes++;
  endtask

  task automatic run_phase(input bit en, input int count, input int tx_pct, input int rx_pct,
                           input bit hold);
    tag_t plain;
    plain = '{1'b0, 16'h0000, 16'h0000};
    set_blanking(en);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    pressure_on = hold;
    for (int i = 0; i < count; i++) offer_sample(next_sample(), plain);
    in_valid = 1'b0;
    pressure_on = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    sample_in = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    pressure_on = 1'b0;
    hold_left = 0;
    release_left = 0;
    holds_done = 0;
    stall_cycles = 0;
    items_in = 0;
    results_out = 0;
    mismatches = 0;
    strays = 0;
    cfg_writes = 0;
    wave_level = 16'h8000;
    blank_en = 1'b1;
    blank_count = 0;
    hp_out_last = '0;
    foreach (lp_in_line[i]) lp_in_line[i] = '0;
    foreach (lp_out_line[i]) lp_out_line[i] = '0;
    foreach (hp_in_line[i]) hp_in_line[i] = '0;
    foreach (slope_line[i]) slope_line[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows inside the blanking window
    set_blanking(1'b1);
    for (int i = 0; i < NUM_DIRECTED; i++)
      offer_sample(DIRECTED[i].sample,
                   '{DIRECTED[i].typed, DIRECTED[i].energy, DIRECTED[i].slope});
    in_valid = 1'b0;

    // blanking off inside the window, then on across its end
    run_phase(1'b0, 15, 0, 0, 1'b0);
    run_phase(1'b1, 210, 0, 0, 1'b0);
    run_phase(1'b0, 200, 74, 0, 1'b0);
    run_phase(1'b1, 200, 0, 74, 1'b0);
    run_phase(1'b0, 200, 28, 28, 1'b0);
    run_phase(1'b1, 200, 0, 0, 1'b1);

    while (energy_due.size() != 0) @(negedge clk);
    repeat (4 * PIPE_DEPTH) @(negedge clk);

    $display("%0d samples in, %0d results out, %0d blanking writes, %0d long output holds",
             items_in, results_out, cfg_writes, holds_done);
    $display("%0d mismatched and %0d unexpected results", mismatches, strays);
    if (mismatches == 0 && strays == 0 && energy_due.size() == 0) begin
      $display("[qrs_energy_filter_chain] OK");
    end else begin
      $display("[qrs_energy_filter_chain] ERROR");
    end
    $finish;
  end

endmodule
